@@ hdl/wlbt_pkg.sv @@
// Shared types, defaults and helpers for the wireless loss block tracker.
// No dependencies; imported by wireless_loss_block_tracker_top.
package wlbt_pkg;

   // default ring depth
   localparam int unsigned RUN_SLOTS_DEF = 16;

   // sequence number width
   localparam int unsigned SEQ_W = 32;

   typedef logic [SEQ_W-1:0] seq_type;

   // action codes of an input word
   localparam logic ACT_DATA = 1'b0;
   localparam logic ACT_ACK  = 1'b1;

   // signed 32-bit a >= b
   function automatic logic seq_ge(input seq_type a, input seq_type b);
      return $signed(a) >= $signed(b);
   endfunction

endpackage

@@ hdl/wireless_loss_block_tracker_top.sv @@
// Wireless loss block tracker: ring of unacked sequence runs, loss mark on acks.
// Depends on wlbt_pkg (types, action codes, signed compare).
//
// Data words pass through the data states and acks through the ack states, then
// ST_RESP raises rsp_strobe; an ack that frees runs walks them one ring slot per
// cycle through a single registered read port. busy is high until the strobe cycle,
// so one word is in flight at a time. The strobe lasts one cycle.
// Synchronous active-high reset: tracker empty, last seq/ack all ones, ring reads 0.
module wireless_loss_block_tracker_top #(
   parameter int unsigned RUN_SLOTS = wlbt_pkg::RUN_SLOTS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_action,
   input  wlbt_pkg::seq_type req_seq_number,
   output logic              rsp_strobe,
   output logic              rsp_mark_loss,
   output logic              rsp_tracker_empty
);
   import wlbt_pkg::*;

   localparam int unsigned IDX_W = (RUN_SLOTS > 1) ? $clog2(RUN_SLOTS) : 1;
   typedef logic [IDX_W-1:0] idx_type;
   localparam idx_type LAST_IDX = idx_type'(RUN_SLOTS - 1);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DATA_DEC,
      ST_DATA_EXT,
      ST_DATA_NEW,
      ST_DATA_OLD,
      ST_ACK_DEC,
      ST_ACK_REP,
      ST_WALK,
      ST_TRIM,
      ST_ACK_FIN,
      ST_RESP
   } state_type;

   function automatic idx_type ring_next(input idx_type i);
      return (i == LAST_IDX) ? '0 : idx_type'(i + 1'b1);
   endfunction

   function automatic idx_type ring_prev(input idx_type i);
      return (i == '0) ? LAST_IDX : idx_type'(i - 1'b1);
   endfunction

   // control and architectural state
   state_type              state_ff, state_in;
   logic                   act_ff, act_in;
   seq_type                seq_ff, seq_in;
   seq_type                seq_inc_ff, seq_inc_in;
   logic                   alive_ff, alive_in;
   logic                   empty_ff, empty_in;
   idx_type                head_ff, head_in;
   idx_type                tail_ff, tail_in;
   seq_type                last_seen_ff, last_seen_in;
   seq_type                last_ack_ff, last_ack_in;
   idx_type                idx_ff, idx_in;
   seq_type                diff_ff, diff_in;
   logic                   mark_ff, mark_in;
   logic [RUN_SLOTS-1:0]   valid_ff, valid_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic                   rsp_mark_ff, rsp_mark_in;
   logic                   rsp_empty_ff, rsp_empty_in;

   // run memory and its ports
   seq_type                mem_start [RUN_SLOTS];
   seq_type                mem_count [RUN_SLOTS];
   logic                   rd_en;
   idx_type                rd_addr;
   seq_type                rd_start_raw_ff;
   seq_type                rd_count_raw_ff;
   logic                   rd_vld_ff;
   logic                   wr_en;
   idx_type                wr_addr;
   seq_type                wr_start;
   seq_type                wr_count;
   logic                   ring_clr;

   // read word, zero for a slot never written since the last clear
   seq_type                rd_start;
   seq_type                rd_count;
   seq_type                run_end;
   logic                   ext_hit;
   logic                   old_hit;
   logic                   beyond;

   assign rd_start = rd_vld_ff ? rd_start_raw_ff : '0;
   assign rd_count = rd_vld_ff ? rd_count_raw_ff : '0;
   assign run_end  = rd_start + rd_count - 1'b1;
   assign ext_hit  = (seq_type'(rd_start + rd_count) == seq_ff);
   assign old_hit  = (seq_ff == seq_type'(rd_start - 1'b1));
   assign beyond   = (rd_start > seq_inc_ff);

   // sequencer: next state and memory port control
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      seq_in        = seq_ff;
      seq_inc_in    = seq_inc_ff;
      alive_in      = alive_ff;
      empty_in      = empty_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      last_seen_in  = last_seen_ff;
      last_ack_in   = last_ack_ff;
      idx_in        = idx_ff;
      diff_in       = diff_ff;
      mark_in       = mark_ff;
      rsp_strobe_in = 1'b0;
      rsp_mark_in   = rsp_mark_ff;
      rsp_empty_in  = rsp_empty_ff;
      rd_en         = 1'b0;
      rd_addr       = tail_ff;
      wr_en         = 1'b0;
      wr_addr       = head_ff;
      wr_start      = seq_ff;
      wr_count      = seq_type'(1);
      ring_clr      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               act_in     = req_action;
               seq_in     = req_seq_number;
               seq_inc_in = req_seq_number + 1'b1;
               mark_in    = 1'b0;
               if (req_action == ACT_DATA) begin
                  // restart on zero sequence number
                  if (alive_ff && (req_seq_number == '0)) begin
                     ring_clr = 1'b1;
                     head_in  = '0;
                     tail_in  = '0;
                     empty_in = 1'b1;
                  end
                  alive_in = 1'b1;
                  state_in = ST_DATA_DEC;
               end else begin
                  state_in = ST_ACK_DEC;
               end
            end
         end

         ST_DATA_DEC: begin
            if (empty_ff && seq_ge(seq_ff, last_ack_ff)) begin
               // first run of an empty ring
               wr_en        = 1'b1;
               wr_addr      = head_ff;
               wr_start     = seq_ff;
               wr_count     = seq_type'(1);
               tail_in      = head_ff;
               head_in      = ring_next(head_ff);
               last_seen_in = seq_ff;
               empty_in     = 1'b0;
               state_in     = ST_RESP;
            end else if (seq_ge(seq_ff, last_seen_ff)) begin
               last_seen_in = seq_ff;
               rd_en        = 1'b1;
               rd_addr      = ring_prev(head_ff);
               state_in     = ST_DATA_EXT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = tail_ff;
               state_in = ST_DATA_OLD;
            end
         end

         ST_DATA_EXT: begin
            if (ext_hit) begin
               // newest run grows by one
               wr_en    = 1'b1;
               wr_addr  = ring_prev(head_ff);
               wr_start = rd_start;
               wr_count = rd_count + 1'b1;
               state_in = ST_RESP;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = head_ff;
               state_in = ST_DATA_NEW;
            end
         end

         ST_DATA_NEW: begin
            // open a run at the head, count adds to whatever the slot holds
            wr_en    = 1'b1;
            wr_addr  = head_ff;
            wr_start = seq_ff;
            wr_count = rd_count + 1'b1;
            head_in  = ring_next(head_ff);
            state_in = ST_RESP;
         end

         ST_DATA_OLD: begin
            // oldest run grows backward by one
            if (old_hit) begin
               wr_en    = 1'b1;
               wr_addr  = tail_ff;
               wr_start = seq_ff;
               wr_count = rd_count + 1'b1;
            end
            state_in = ST_RESP;
         end

         ST_ACK_DEC: begin
            if (seq_ff == last_ack_ff) begin
               rd_en    = 1'b1;
               rd_addr  = tail_ff;
               state_in = ST_ACK_REP;
            end else if (!seq_ge(seq_ff, last_ack_ff)) begin
               state_in = ST_RESP;
            end else begin
               idx_in = tail_ff;
               if (tail_ff == head_ff) begin
                  state_in = ST_ACK_FIN;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = tail_ff;
                  state_in = ST_WALK;
               end
            end
         end

         ST_ACK_REP: begin
            mark_in  = (head_ff == tail_ff) || beyond;
            state_in = ST_RESP;
         end

         ST_WALK: begin
            if (run_end <= seq_ff) begin
               // whole run covered: free it, fetch the next one
               wr_en    = 1'b1;
               wr_addr  = idx_ff;
               wr_start = '0;
               wr_count = '0;
               idx_in   = ring_next(idx_ff);
               if (ring_next(idx_ff) == head_ff) begin
                  state_in = ST_ACK_FIN;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = ring_next(idx_ff);
               end
            end else if (seq_ff < rd_start) begin
               mark_in  = beyond;
               state_in = ST_ACK_FIN;
            end else begin
               diff_in  = seq_ff - rd_start;
               state_in = ST_TRIM;
            end
         end

         ST_TRIM: begin
            // count - (ack - start + 1) == count + ~(ack - start)
            wr_en    = 1'b1;
            wr_addr  = idx_ff;
            wr_start = seq_inc_ff;
            wr_count = rd_count + ~diff_ff;
            state_in = ST_ACK_FIN;
         end

         ST_ACK_FIN: begin
            tail_in     = idx_ff;
            last_ack_in = seq_ff;
            if (idx_ff == head_ff) begin
               empty_in = 1'b1;
            end
            state_in = ST_RESP;
         end

         ST_RESP: begin
            rsp_strobe_in = 1'b1;
            rsp_mark_in   = mark_ff;
            rsp_empty_in  = empty_ff;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // valid bits: cleared on restart, set by any write
   always_comb begin
      valid_in = ring_clr ? '0 : valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      seq_ff      <= seq_in;
      seq_inc_ff  <= seq_inc_in;
      idx_ff      <= idx_in;
      diff_ff     <= diff_in;
      mark_ff     <= mark_in;
      rsp_mark_ff <= rsp_mark_in;
      rsp_empty_ff <= rsp_empty_in;
      if (reset) begin
         state_ff      <= ST_IDLE;
         alive_ff      <= 1'b0;
         empty_ff      <= 1'b1;
         head_ff       <= '0;
         tail_ff       <= '0;
         last_seen_ff  <= '1;
         last_ack_ff   <= '1;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         alive_ff      <= alive_in;
         empty_ff      <= empty_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         last_seen_ff  <= last_seen_in;
         last_ack_ff   <= last_ack_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // run memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_start[wr_addr] <= wr_start;
         mem_count[wr_addr] <= wr_count;
      end
      if (rd_en) begin
         rd_start_raw_ff <= mem_start[rd_addr];
         rd_count_raw_ff <= mem_count[rd_addr];
         rd_vld_ff       <= valid_ff[rd_addr];
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_mark_loss     = rsp_mark_ff;
   assign rsp_tracker_empty = rsp_empty_ff;

   // checks
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while sequencer busy");

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   a_data_no_mark: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (act_ff == ACT_DATA)) |-> !rsp_mark_loss)
      else $error("loss mark on a data word");

   a_walk_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> (idx_ff != head_ff))
      else $error("ack walk reached the head slot");

endmodule

@@ tb/tb_wireless_loss_block_tracker_top.sv @@
// Self-checking testbench for wireless_loss_block_tracker_top: directed words, TCP-like
// random traffic, then signed limits; every result checked against an in-bench prediction.
// Depends on wlbt_pkg (seq_type, action codes) and the RTL top level.
`timescale 1ns / 100ps

module tb_wireless_loss_block_tracker_top;
   import wlbt_pkg::*;

   localparam int unsigned RING        = RUN_SLOTS_DEF;
   localparam int unsigned STALL_LIMIT = 4000;
   localparam int unsigned DRAIN_LIMIT = 500;

   typedef struct packed {
      logic mark_loss;
      logic tracker_empty;
   } tracker_flags_type;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   logic    req_action;
   seq_type req_seq_number;
   logic    rsp_strobe;
   logic    rsp_mark_loss;
   logic    rsp_tracker_empty;

   // predicted tracker state
   logic    pr_alive;
   logic    pr_empty;
   int unsigned pr_head;
   int unsigned pr_tail;
   seq_type pr_seen;
   seq_type pr_ack;
   seq_type pr_start [RING];
   seq_type pr_count [RING];

   tracker_flags_type expected_flags_q [$];
   int unsigned    mismatch_count;
   int unsigned    stall_cycles;
   int unsigned    idle_pct;

   wireless_loss_block_tracker_top #(.RUN_SLOTS(RING)) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_seq_number    (req_seq_number),
      .rsp_strobe        (rsp_strobe),
      .rsp_mark_loss     (rsp_mark_loss),
      .rsp_tracker_empty (rsp_tracker_empty)
   );

   always #5 clock = ~clock;

   // signed 32-bit a >= b
   function automatic logic not_below(input seq_type a, input seq_type b);
      return $signed(a) >= $signed(b);
   endfunction

   function automatic void clear_runs();
      pr_empty = 1'b1;
      pr_head  = 0;
      pr_tail  = 0;
      for (int k = 0; k < RING; k++) begin
         pr_start[k] = '0;
         pr_count[k] = '0;
      end
   endfunction

   // ring reads empty, or oldest run starts past ack+1
   function automatic logic loss_pending(input seq_type ack);
      return (pr_head == pr_tail) || (pr_start[pr_tail] > seq_type'(ack + 1));
   endfunction

   // data word: extend newest run, open one at head, or extend oldest run backward
   function automatic void apply_data(input seq_type seq);
      int unsigned slot;
      if (pr_alive && seq == '0)
         clear_runs();
      pr_alive = 1'b1;
      if (pr_empty && not_below(seq, pr_ack)) begin
         slot           = pr_head;
         pr_start[slot] = seq;
         pr_count[slot] = 1;
         pr_tail        = slot;
         pr_head        = (slot + 1) % RING;
         pr_seen        = seq;
         pr_empty       = 1'b0;
         return;
      end
      if (not_below(seq, pr_seen)) begin
         pr_seen = seq;
         slot    = (pr_head + RING - 1) % RING;
         if (seq_type'(pr_start[slot] + pr_count[slot]) == seq) begin
            pr_count[slot] = pr_count[slot] + 1;
            return;
         end
         slot    = pr_head;
         pr_head = (slot + 1) % RING;
      end else begin
         slot = pr_tail;
         if (seq != seq_type'(pr_start[slot] - 1))
            return;
      end
      pr_start[slot] = seq;
      pr_count[slot] = pr_count[slot] + 1;
   endfunction

   // ack word: free or trim runs from the oldest one, return the loss mark
   function automatic logic apply_ack(input seq_type ack);
      int unsigned slot;
      int unsigned n;
      logic        walking;
      seq_type     run_end;
      if (ack == pr_ack)
         return loss_pending(ack);
      if (!not_below(ack, pr_ack))
         return 1'b0;
      slot    = pr_tail;
      n       = 0;
      walking = 1'b1;
      while (walking && n < RING && slot != pr_head) begin
         run_end = pr_start[slot] + pr_count[slot] - 1;
         if (run_end <= ack) begin
            pr_start[slot] = '0;
            pr_count[slot] = '0;
            slot = (slot + 1) % RING;
            n++;
         end else if (ack < pr_start[slot]) begin
            walking = 1'b0;
         end else begin
            pr_count[slot] = pr_count[slot] - (ack - pr_start[slot] + 1);
            pr_start[slot] = ack + 1;
            walking = 1'b0;
         end
      end
      pr_tail = slot;
      if (pr_tail == pr_head)
         pr_empty = 1'b1;
      pr_ack = ack;
      return (pr_head != pr_tail) && loss_pending(ack);
   endfunction

   function automatic tracker_flags_type predict_flags(input logic act, input seq_type seq);
      tracker_flags_type flags;
      flags.mark_loss = 1'b0;
      if (act == ACT_DATA)
         apply_data(seq);
      else
         flags.mark_loss = apply_ack(seq);
      flags.tracker_empty = pr_empty;
      return flags;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns  mismatch: %s", $time, what);
   endtask

   // present one word, hold it until accepted, then record its prediction
   task automatic send_word(input logic act, input seq_type seq);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start          = 1'b1;
      req_action     = act;
      req_seq_number = seq;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      expected_flags_q.push_back(predict_flags(act, seq));
   endtask

   // stop sending and wait for every outstanding result plus the pipeline tail
   task automatic drain_tracker();
      int unsigned waited;
      @(negedge clock);
      start  = 1'b0;
      waited = 0;
      while (expected_flags_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (RING + 8) @(posedge clock);
   endtask

   // result checker: one strobe, one expectation
   always @(posedge clock) begin : check_results
      tracker_flags_type exp_flags;
      if (!reset && rsp_strobe) begin
         if (expected_flags_q.size() == 0) begin
            report_mismatch("result word with nothing expected");
         end else begin
            exp_flags = expected_flags_q.pop_front();
            if (rsp_mark_loss !== exp_flags.mark_loss)
               report_mismatch($sformatf("mark_loss got %b exp %b",
                                         rsp_mark_loss, exp_flags.mark_loss));
            if (rsp_tracker_empty !== exp_flags.tracker_empty)
               report_mismatch($sformatf("tracker_empty got %b exp %b",
                                         rsp_tracker_empty, exp_flags.tracker_empty));
         end
      end
   end

   // watchdog on cycles with no accepted word in either direction
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("watchdog expired after %0d idle cycles", stall_cycles);
         $display("FAIL wireless_loss_block_tracker_top");
         $finish;
      end
   end

   // acks against the reset state: repeat of all ones, then the signed minimum below it
   task automatic test_reset_state_acks();
      send_word(ACT_ACK, 32'hFFFF_FFFF);
      send_word(ACT_ACK, 32'h8000_0000);
   endtask

   // first run, extension, backward extension, stale word, second run
   task automatic test_run_building();
      send_word(ACT_DATA, 32'd100);
      send_word(ACT_DATA, 32'd101);
      send_word(ACT_DATA, 32'd102);
      send_word(ACT_DATA, 32'd99);
      send_word(ACT_DATA, 32'd50);
      send_word(ACT_DATA, 32'd110);
      send_word(ACT_DATA, 32'd111);
   endtask

   // trim the oldest run, repeat, free one run with a hole left, free all
   task automatic test_ack_trimming();
      send_word(ACT_ACK, 32'd101);
      send_word(ACT_ACK, 32'd101);
      send_word(ACT_ACK, 32'd105);
      send_word(ACT_ACK, 32'd111);
   endtask

   // empty ring with data below the last ack: run opens, empty flag stays set
   task automatic test_empty_below_ack();
      send_word(ACT_ACK, 32'd200);
      send_word(ACT_DATA, 32'd150);
      send_word(ACT_DATA, 32'hFFFF_FFFF);
      send_word(ACT_ACK, 32'd201);
   endtask

   // zero on a live tracker clears the ring
   task automatic test_restart_on_zero();
      send_word(ACT_DATA, 32'd0);
      send_word(ACT_DATA, 32'd300);
      send_word(ACT_DATA, 32'd0);
   endtask

   // signed limits; run last since they pin last seen and last ack at the top
   task automatic test_signed_extremes();
      send_word(ACT_DATA, 32'h7FFF_FFFF);
      send_word(ACT_ACK, 32'h7FFF_FFFF);
      send_word(ACT_DATA, 32'h8000_0000);
      send_word(ACT_ACK, 32'hFFFF_FFFF);
   endtask

   // one TCP-like flow: in-order data, holes, bursts that wrap the ring, acks,
   // retransmissions, restarts and negative noise words
   task automatic test_random_traffic(input int unsigned items, input int unsigned idle);
      seq_type     next_seq;
      seq_type     acked;
      seq_type     span;
      seq_type     word_seq;
      int unsigned burst_left;
      int unsigned pick;
      idle_pct   = idle;
      burst_left = 0;
      next_seq   = (not_below(pr_seen, pr_ack) ? pr_seen : pr_ack) + $urandom_range(1, 40);
      acked      = pr_ack;
      for (int unsigned k = 0; k < items; k++) begin
         pick = $urandom_range(99);
         if (burst_left > 0) begin
            burst_left--;
            next_seq = next_seq + $urandom_range(2, 6);
            send_word(ACT_DATA, next_seq);
            next_seq = next_seq + 1;
         end else if (pick < 2) begin
            burst_left = $urandom_range(12, 24);
            send_word(ACT_DATA, next_seq);
            next_seq = next_seq + 1;
         end else if (pick < 40) begin
            send_word(ACT_DATA, next_seq);
            next_seq = next_seq + 1;
         end else if (pick < 50) begin
            next_seq = next_seq + $urandom_range(1, 8);
            send_word(ACT_DATA, next_seq);
            next_seq = next_seq + 1;
         end else if (pick < 56) begin
            send_word(ACT_DATA, pr_start[pr_tail] - 1);
         end else if (pick < 60) begin
            send_word(ACT_DATA, next_seq - $urandom_range(1, 30));
         end else if (pick < 80) begin
            span = next_seq - 1 - acked;
            if ($signed(span) <= 0)
               word_seq = acked;
            else if ($urandom_range(1))
               word_seq = next_seq - 1;
            else
               word_seq = acked + $urandom_range(1, span);
            send_word(ACT_ACK, word_seq);
         end else if (pick < 84) begin
            // ack past everything sent
            send_word(ACT_ACK, next_seq + $urandom_range(0, 3));
         end else if (pick < 91) begin
            send_word(ACT_ACK, acked);
         end else if (pick < 94) begin
            send_word(ACT_ACK, acked - $urandom_range(1, 20));
         end else if (pick < 96) begin
            send_word(ACT_DATA, '0);
         end else begin
            word_seq = {1'b1, 31'($urandom)};
            send_word(logic'($urandom_range(1)), word_seq);
         end
         // keep the flow in step with what the tracker has seen
         acked = pr_ack;
         if (not_below(pr_seen, next_seq))
            next_seq = pr_seen + 1;
      end
      drain_tracker();
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      start          = 1'b0;
      req_action     = ACT_DATA;
      req_seq_number = '0;
      mismatch_count = 0;
      stall_cycles   = 0;
      idle_pct       = 0;
      pr_alive       = 1'b0;
      pr_seen        = '1;
      pr_ack         = '1;
      clear_runs();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_state_acks();
      test_run_building();
      test_ack_trimming();
      test_empty_below_ack();
      test_restart_on_zero();
      drain_tracker();

      test_random_traffic(620, 0);
      test_random_traffic(620, 88);
      test_random_traffic(610, 14);

      idle_pct = 0;
      test_signed_extremes();
      drain_tracker();

      if (expected_flags_q.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   expected_flags_q.size()));
      if (mismatch_count == 0)
         $display("PASS wireless_loss_block_tracker_top");
      else
         $display("FAIL wireless_loss_block_tracker_top");
      $finish;
   end

endmodule
